### sv/fle_pkg.sv
// Package for the From-line escaper: window size, character codes and the
// per-cell control word shared by the cells and the top level.
// Depends on nothing.
`default_nettype none

package fle_pkg;

  localparam int WINDOW_DEPTH = 5;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

  localparam logic [7:0] QUOTE_CHAR = 8'h3E;
  localparam logic [7:0] LINE_FEED  = 8'h0A;
  localparam logic [7:0] CAP_F      = 8'h46;

  // "From " with entry 0 holding the 'F'.
  localparam logic [WINDOW_DEPTH-1:0][7:0] FROM_PATTERN =
    {8'h20, 8'h6D, 8'h6F, 8'h72, CAP_F};

  typedef struct packed {
    logic shift;  // take the neighbor's byte
    logic load;   // take the incoming word
  } fle_cell_ctl_t;

endpackage

`default_nettype wire

### sv/fle_cell.sv
// One cell of the lookahead window: holds one byte, shifts toward the head
// and flags a match against its fixed character of "From ".
// Depends on fle_pkg.
`default_nettype none

module fle_cell
  import fle_pkg::*;
#(
  parameter logic [7:0] MATCH_BYTE = CAP_F
) (
  input  wire logic          clk,
  input  wire fle_cell_ctl_t ctl,
  input  wire logic [7:0]    new_byte,
  input  wire logic [7:0]    next_byte,
  output logic [7:0]         cell_byte,
  output logic               match
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cell_byte <= new_byte;
    end else if (ctl.shift) begin
      cell_byte <= next_byte;
    end
  end

  assign match = (cell_byte == MATCH_BYTE);

endmodule

`default_nettype wire

### sv/from_line_escaper_top.sv
// From-line escaper: a word leaves once four more words of its message have
// arrived, or during the end-of-message flush; the output is registered.
// One word per cycle while the output is not stalled, each inserted '>' taking a
// word's slot; the flush, with input held off, drains one held word per cycle as well.
// Synchronous reset clears the fill count, flush and line-start flags and the
// result valid; the window bytes are not cleared.
`default_nettype none

module from_line_escaper_top
  import fle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       msg_valid,
  output logic            msg_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_message,
  output logic            esc_valid,
  input  wire logic       esc_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  localparam logic [CNT_W-1:0] FULL = CNT_W'(WINDOW_DEPTH);

  logic [CNT_W-1:0] cnt;
  logic             flushing;
  logic             after_line_start;
  logic             quote_done;

  logic [WINDOW_DEPTH-1:0][7:0] bytes;
  logic [WINDOW_DEPTH-1:0]      match;
  fle_cell_ctl_t                ctl [WINDOW_DEPTH];

  logic             head_ready, quote_needed, space, gen, do_quote, release_head;
  logic             accept, last_out;
  logic [CNT_W-1:0] widx;
  logic [7:0]       head;

  assign head         = bytes[0];
  assign head_ready   = (cnt == FULL) || (flushing && (cnt != '0));
  assign quote_needed = after_line_start && (cnt == FULL) && (&match) && !quote_done;
  assign space        = !esc_valid || esc_ready;
  assign gen          = head_ready && space;
  assign do_quote     = gen && quote_needed;
  assign release_head = gen && !quote_needed;
  assign last_out     = flushing && (cnt == CNT_W'(1));

  assign msg_ready = !flushing && ((cnt != FULL) || release_head);
  assign accept    = msg_valid && msg_ready;
  assign widx      = cnt - CNT_W'(release_head);

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW_DEPTH; gi++) begin : g_cell
      logic [7:0] right_byte;
      if (gi == WINDOW_DEPTH - 1) begin : g_tail
        assign right_byte = data_byte;
      end else begin : g_mid
        assign right_byte = bytes[gi+1];
      end

      assign ctl[gi].shift = release_head;
      assign ctl[gi].load  = accept && (widx == CNT_W'(gi));

      fle_cell #(
        .MATCH_BYTE(FROM_PATTERN[gi])
      ) u_cell (
        .clk      (clk),
        .ctl      (ctl[gi]),
        .new_byte (data_byte),
        .next_byte(right_byte),
        .cell_byte(bytes[gi]),
        .match    (match[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt              <= '0;
      flushing         <= 1'b0;
      after_line_start <= 1'b0;
      quote_done       <= 1'b0;
    end else begin
      cnt <= cnt - CNT_W'(release_head) + CNT_W'(accept);

      if (accept && end_of_message) begin
        flushing <= 1'b1;
      end else if (release_head && last_out) begin
        flushing <= 1'b0;
      end

      // '>' keeps line-start; line feed sets it; message end or any other byte clears it.
      if (release_head) begin
        if (last_out) begin
          after_line_start <= 1'b0;
        end else if (head == LINE_FEED) begin
          after_line_start <= 1'b1;
        end else if (head != QUOTE_CHAR) begin
          after_line_start <= 1'b0;
        end
      end

      if (do_quote) begin
        quote_done <= 1'b1;
      end else if (release_head) begin
        quote_done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_valid <= 1'b0;
    end else if (gen) begin
      esc_valid <= 1'b1;
    end else if (esc_ready) begin
      esc_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gen) begin
      out_byte <= do_quote ? QUOTE_CHAR : head;
      out_last <= release_head && last_out;
    end
  end

endmodule

`default_nettype wire

### test/from_line_escaper_top_tb.sv
`timescale 1ns / 100ps
// Testbench for from_line_escaper_top: it streams messages in, predicts the
// escaped output per accepted word and checks every output word in order.
// Depends on fle_pkg and from_line_escaper_top.

module from_line_escaper_top_tb
  import fle_pkg::*;
();

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } esc_word_t;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_PCT = 28;

  logic       clk = 1'b0;
  logic       rst;
  logic       msg_valid;
  logic       msg_ready;
  logic [7:0] data_byte;
  logic       end_of_message;
  logic       esc_valid;
  logic       esc_ready;
  logic [7:0] out_byte;
  logic       out_last;

  // Predictor state: bytes held back, how many, and the line-start flag.
  logic [7:0] held_bytes [WINDOW_DEPTH];
  int         held_count;
  bit         line_start_seen;

  esc_word_t  expected_escaped [$];
  esc_word_t  oldest;
  logic [7:0] msg_text [$];
  int         words_sent;
  int         mismatches;
  int         stall_cycles;
  bit         gaps_off;

  from_line_escaper_top dut (
    .clk            (clk),
    .rst            (rst),
    .msg_valid      (msg_valid),
    .msg_ready      (msg_ready),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .esc_valid      (esc_valid),
    .esc_ready      (esc_ready),
    .out_byte       (out_byte),
    .out_last       (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Release the oldest held byte, quoting it first when it opens a
  // "From " that follows a line feed and any run of '>' characters.
  task automatic release_oldest(input logic last);
    logic [7:0] head;
    bit         matched;
    head = held_bytes[0];
    if (head == LINE_FEED) begin
      line_start_seen = 1'b1;
    end else if (head == CAP_F) begin
      matched = (held_count >= WINDOW_DEPTH);
      for (int k = 1; k < WINDOW_DEPTH; k++) begin
        if (held_bytes[k] != FROM_PATTERN[k]) matched = 1'b0;
      end
      if (line_start_seen && matched) expected_escaped.push_back({QUOTE_CHAR, 1'b0});
      line_start_seen = 1'b0;
    end else if (head != QUOTE_CHAR) begin
      line_start_seen = 1'b0;
    end
    expected_escaped.push_back({head, last});
    for (int k = 0; k < WINDOW_DEPTH - 1; k++) held_bytes[k] = held_bytes[k + 1];
    if (held_count > 0) held_count--;
  endtask

  task automatic predict_escaped(input logic [7:0] b, input logic eom);
    if (held_count > WINDOW_DEPTH - 1) held_count = WINDOW_DEPTH - 1;
    held_bytes[held_count] = b;
    held_count++;
    if (!eom) begin
      if (held_count >= WINDOW_DEPTH) release_oldest(1'b0);
    end else begin
      while (held_count > 0) release_oldest(held_count == 1);
      line_start_seen = 1'b0;
    end
  endtask

  // Every return happens in a time step where msg_valid was not assigned.
  task automatic send_word(input logic [7:0] b, input logic eom);
    msg_valid      <= 1'b1;
    data_byte      <= b;
    end_of_message <= eom;
    do @(posedge clk); while (!msg_ready);
    predict_escaped(b, eom);
    words_sent++;
    while (!gaps_off && $urandom_range(99) < IDLE_PCT) begin
      msg_valid      <= 1'b0;
      data_byte      <= 8'($urandom);
      end_of_message <= 1'($urandom);
      @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    msg_valid <= 1'b0;
    while (expected_escaped.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
  endtask

  task automatic send_message(input int pause_at);
    for (int i = 0; i < msg_text.size(); i++) begin
      if (i == pause_at) wait_for_drain();
      send_word(msg_text[i], i == msg_text.size() - 1);
    end
  endtask

  // Mostly line feeds, quote runs and "From " pieces, so that quoting is
  // exercised often; the random length cut leaves broken tails too.
  task automatic build_message();
    int    target;
    string piece;
    msg_text.delete();
    target = ($urandom_range(9) == 0) ? $urandom_range(1, 5) : $urandom_range(6, 30);
    while (msg_text.size() < target) begin
      case ($urandom_range(9))
        0, 1: msg_text.push_back(LINE_FEED);
        2: repeat ($urandom_range(1, 3)) msg_text.push_back(QUOTE_CHAR);
        3, 4: begin
          piece = "From ";
          for (int i = 0; i < piece.len(); i++) msg_text.push_back(piece[i]);
        end
        5: begin
          piece = "From ";
          for (int i = 0; i < $urandom_range(1, 4); i++) msg_text.push_back(piece[i]);
          msg_text.push_back(8'($urandom));
        end
        6: begin
          piece = "\nFrom ";
          for (int i = 0; i < piece.len(); i++) msg_text.push_back(piece[i]);
        end
        default: msg_text.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    while (msg_text.size() > target) void'(msg_text.pop_back());
  endtask

  task automatic test_single_byte_messages();
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b1);
  endtask

  // A "From " at the very start of a message stays as it is.
  task automatic test_leading_from();
    send_text("From ");
  endtask

  // Quoted lines, each ending exactly on the message end.
  task automatic test_quoted_from_lines();
    send_text("\nFrom ");
    send_text("\n>From ");
  endtask

  // An 'F' with fewer than four bytes after it is never quoted.
  task automatic test_short_tail();
    send_text("\nFrom");
  endtask

  task automatic test_random_text();
    bit paused_once;
    int pause_at;
    paused_once = 1'b0;
    while (words_sent < 300) begin
      build_message();
      if (!paused_once && msg_text.size() > 2) begin
        pause_at    = msg_text.size() / 2;
        paused_once = 1'b1;
      end else begin
        pause_at = ($urandom_range(7) == 0) ? $urandom_range(0, msg_text.size() - 1) : -1;
      end
      send_message(pause_at);
    end
  endtask

  task automatic test_streaming_no_gaps();
    int start_count;
    gaps_off    = 1'b1;
    start_count = words_sent;
    while (words_sent - start_count < 70) begin
      build_message();
      send_message(-1);
    end
    gaps_off = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      esc_ready <= 1'b0;
    end else begin
      if (esc_valid && esc_ready) begin
        if (expected_escaped.size() == 0) begin
          $display("%0t: unexpected word, actual out_byte %02h out_last %0b",
                   $time, out_byte, out_last);
          mismatches++;
        end else begin
          oldest = expected_escaped.pop_front();
          if (out_byte !== oldest.value) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, oldest.value, out_byte);
            mismatches++;
          end
          if (out_last !== oldest.last) begin
            $display("%0t: out_last expected %0b actual %0b", $time, oldest.last, out_last);
            mismatches++;
          end
        end
      end
      esc_ready <= gaps_off || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((msg_valid && msg_ready) || (esc_valid && esc_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst             = 1'b1;
    msg_valid       = 1'b0;
    data_byte       = 8'h00;
    end_of_message  = 1'b0;
    esc_ready       = 1'b0;
    held_count      = 0;
    line_start_seen = 1'b0;
    words_sent      = 0;
    mismatches      = 0;
    stall_cycles    = 0;
    gaps_off        = 1'b0;
    for (int k = 0; k < WINDOW_DEPTH; k++) held_bytes[k] = 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_byte_messages();
    test_leading_from();
    test_quoted_from_lines();
    test_short_tail();
    test_random_text();
    test_streaming_no_gaps();

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_escaped.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
